// ===== design/scrolling_tile_slot_map_defines.svh =====
// ============================================================================
// Scrolling tile slot map - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ============================================================================
`ifndef SCROLLING_TILE_SLOT_MAP_DEFINES_SVH
`define SCROLLING_TILE_SLOT_MAP_DEFINES_SVH

// Same-cycle implication.
`define STSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define STSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stsm_pkg.sv =====
// ============================================================================
// Scrolling tile slot map - package
// Op codes, coordinate width and the cell control bundle.
// ============================================================================
package stsm_pkg;

    // Grid coordinates compare at this width (grid dimensions up to 32).
    localparam int COORD_W = 5;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_MARK   = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_DOWN   = 3'd3,
        OP_LEFT   = 3'd4,
        OP_RIGHT  = 3'd5,
        OP_UP     = 3'd6
    } op_t;

    // Broadcast to every cell; at most one bit high.
    typedef struct packed {
        logic clear_all;
        logic scroll_down;
        logic scroll_up;
        logic scroll_left;
        logic scroll_right;
        logic mark;
    } ctrl_t;

endpackage

// ===== design/stsm_cell.sv =====
// ============================================================================
// Scrolling tile slot map - grid cell
// Holds one map entry (slot number) and the loaded bit of that slot; takes
// its neighbor's entry on a scroll.
// ============================================================================
module stsm_cell
    import stsm_pkg::*;
#(
    parameter int SLOT_W     = 6,
    parameter int INIT_SLOT  = 0,
    parameter bit WRAP_DOWN  = 1'b0,
    parameter bit WRAP_UP    = 1'b0,
    parameter bit WRAP_LEFT  = 1'b0,
    parameter bit WRAP_RIGHT = 1'b0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_t             ctrl,
    input  logic              sel,
    // entry this cell takes on each scroll direction
    input  logic [SLOT_W-1:0] src_down_slot,
    input  logic              src_down_loaded,
    input  logic [SLOT_W-1:0] src_up_slot,
    input  logic              src_up_loaded,
    input  logic [SLOT_W-1:0] src_left_slot,
    input  logic              src_left_loaded,
    input  logic [SLOT_W-1:0] src_right_slot,
    input  logic              src_right_loaded,
    output logic [SLOT_W-1:0] slot,
    output logic              loaded
);

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              loaded_reg;
    logic              loaded_next;

    always_comb
    begin
        slot_next   = slot_reg;
        loaded_next = loaded_reg;
        if (ctrl.clear_all)
        begin
            loaded_next = 1'b0;
        end
        else if (ctrl.scroll_down)
        begin
            slot_next   = src_down_slot;
            loaded_next = WRAP_DOWN ? 1'b0 : src_down_loaded;
        end
        else if (ctrl.scroll_up)
        begin
            slot_next   = src_up_slot;
            loaded_next = WRAP_UP ? 1'b0 : src_up_loaded;
        end
        else if (ctrl.scroll_left)
        begin
            slot_next   = src_left_slot;
            loaded_next = WRAP_LEFT ? 1'b0 : src_left_loaded;
        end
        else if (ctrl.scroll_right)
        begin
            slot_next   = src_right_slot;
            loaded_next = WRAP_RIGHT ? 1'b0 : src_right_loaded;
        end
        else if (ctrl.mark && sel)
        begin
            loaded_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg   <= SLOT_W'(INIT_SLOT);
            loaded_reg <= 1'b0;
        end
        else
        begin
            slot_reg   <= slot_next;
            loaded_reg <= loaded_next;
        end
    end

    assign slot   = slot_reg;
    assign loaded = loaded_reg;

endmodule

// ===== design/scrolling_tile_slot_map.sv =====
// ============================================================================
// Scrolling tile slot map - top level
// Grid of cells mapping window positions to storage slots, with loaded marks.
// ============================================================================
//
//  channel  | dir | tdata                               | tuser
//  ---------+-----+-------------------------------------+-----------
//  s_axis   | in  | col[2:0] row[5:3] tile_valid[6]     | op[2:0]
//  m_axis   | out | slot[5:0] hit[6]                    | -
//
//  One transaction per clock while m_axis is not stalled: every op, scrolls
//  included, is applied to the whole cell grid in the cycle it is accepted;
//  its result sits in the output register in the next cycle.
//  Throughput is set by the output register: a new transaction is taken
//  whenever that register is empty or is being drained in the same cycle.
//  Reset (rst_n low, async) loads cell i with slot i and clears every loaded
//  mark; the block is ready as soon as reset is released.
//  A stalled m_axis holds the result and back-pressures s_axis; no state moves.
//
//  The loaded mark of a slot lives in the cell that holds that slot and moves
//  with it on scrolls (the map is always a permutation); a wrapped slot loses it.
// ============================================================================
module scrolling_tile_slot_map
    import stsm_pkg::*;
#(
    parameter int GRID_WIDTH  = 8,
    parameter int GRID_HEIGHT = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // col[2:0], row[5:3], tile_valid[6], pad[7]
    input  logic [2:0] s_axis_tuser,   // op[2:0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // slot[5:0], hit[6], pad[7]
);

`include "scrolling_tile_slot_map_defines.svh"

    localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int SLOT_W = (NCELLS > 1) ? $clog2(NCELLS) : 1;

    // input fields
    logic [2:0] in_col;
    logic [2:0] in_row;
    logic       in_tile_valid;
    op_t        in_op;
    logic       accept;

    // cell grid
    ctrl_t             ctrl;
    logic [NCELLS-1:0] match_vec;
    logic [NCELLS-1:0] cell_loaded_vec;
    logic [SLOT_W-1:0] cell_slot [NCELLS];

    // lookup read-out
    logic [SLOT_W-1:0] lookup_slot;
    logic              lookup_hit;

    // output register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [5:0] out_slot_reg;
    logic [5:0] out_slot_next;
    logic       out_hit_reg;
    logic       out_hit_next;

    assign in_col        = s_axis_tdata[2:0];
    assign in_row        = s_axis_tdata[5:3];
    assign in_tile_valid = s_axis_tdata[6];
    assign in_op         = op_t'(s_axis_tuser);

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Op decode, broadcast to every cell. Unused op code does nothing.
    always_comb
    begin
        ctrl = '0;
        if (accept)
        begin
            case (in_op)
                OP_MARK:  ctrl.mark         = in_tile_valid;
                OP_CLEAR: ctrl.clear_all    = 1'b1;
                OP_DOWN:  ctrl.scroll_down  = 1'b1;
                OP_LEFT:  ctrl.scroll_left  = 1'b1;
                OP_RIGHT: ctrl.scroll_right = 1'b1;
                OP_UP:    ctrl.scroll_up    = 1'b1;
                default:  ctrl = '0;
            endcase
        end
    end

    // Cell (c, r) sits at index r*GRID_WIDTH + c. Sources follow the scroll:
    // down takes the cell above in index (r+1), left takes c+1, with wrap.
    for (genvar gr = 0; gr < GRID_HEIGHT; gr++)
    begin : g_row
        for (genvar gc = 0; gc < GRID_WIDTH; gc++)
        begin : g_col
            localparam int IDX = gr * GRID_WIDTH + gc;
            localparam int DN  = ((gr + 1) % GRID_HEIGHT) * GRID_WIDTH + gc;
            localparam int UPI = ((gr + GRID_HEIGHT - 1) % GRID_HEIGHT) * GRID_WIDTH + gc;
            localparam int LF  = gr * GRID_WIDTH + (gc + 1) % GRID_WIDTH;
            localparam int RT  = gr * GRID_WIDTH + (gc + GRID_WIDTH - 1) % GRID_WIDTH;

            // Positions outside the grid match no cell.
            assign match_vec[IDX] = (COORD_W'(in_col) == COORD_W'(gc)) &&
                                    (COORD_W'(in_row) == COORD_W'(gr));

            stsm_cell #(
                .SLOT_W     (SLOT_W),
                .INIT_SLOT  (IDX),
                .WRAP_DOWN  (gr == GRID_HEIGHT - 1),
                .WRAP_UP    (gr == 0),
                .WRAP_LEFT  (gc == GRID_WIDTH - 1),
                .WRAP_RIGHT (gc == 0)
            ) u_cell (
                .clk              (clk),
                .rst_n            (rst_n),
                .ctrl             (ctrl),
                .sel              (match_vec[IDX]),
                .src_down_slot    (cell_slot[DN]),
                .src_down_loaded  (cell_loaded_vec[DN]),
                .src_up_slot      (cell_slot[UPI]),
                .src_up_loaded    (cell_loaded_vec[UPI]),
                .src_left_slot    (cell_slot[LF]),
                .src_left_loaded  (cell_loaded_vec[LF]),
                .src_right_slot   (cell_slot[RT]),
                .src_right_loaded (cell_loaded_vec[RT]),
                .slot             (cell_slot[IDX]),
                .loaded           (cell_loaded_vec[IDX])
            );
        end
    end

    // One-hot select OR of the addressed cell; all zero when off the grid.
    always_comb
    begin
        lookup_slot = '0;
        lookup_hit  = 1'b0;
        for (int i = 0; i < NCELLS; i++)
        begin
            lookup_slot = lookup_slot | (match_vec[i] ? cell_slot[i] : '0);
            lookup_hit  = lookup_hit | (match_vec[i] & cell_loaded_vec[i]);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_slot_next  = out_slot_reg;
        out_hit_next   = out_hit_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_slot_next  = '0;
            out_hit_next   = 1'b0;
            if (in_op == OP_LOOKUP)
            begin
                out_slot_next = 6'(lookup_slot);
                out_hit_next  = lookup_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_slot_reg <= out_slot_next;
        out_hit_reg  <= out_hit_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_hit_reg, out_slot_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `STSM_ASSERT_NOW(a_match_onehot, 1'b1, $onehot0(match_vec),
        "more than one cell addressed")
    `STSM_ASSERT_NEXT(a_non_lookup_zero, accept && (in_op != OP_LOOKUP),
        (out_slot_reg == 6'd0) && !out_hit_reg, "non-lookup result not zero")
    `STSM_ASSERT_NEXT(a_clear_all, accept && (in_op == OP_CLEAR),
        cell_loaded_vec == '0, "loaded mark survived clear")
    `STSM_ASSERT_NEXT(a_mark_sets, ctrl.mark && (|match_vec),
        |(cell_loaded_vec & $past(match_vec)), "mark did not set loaded")

endmodule

// ===== tb/sv/scrolling_tile_slot_map_test.sv =====
// ============================================================================
// Scrolling tile slot map - testbench
// Drives op transactions on s_axis and scoreboards every m_axis result
// against a behavioral slot map held in the bench. A directed table comes
// first, then randomized traffic in phases with source gaps and sink stalls.
// ============================================================================
module scrolling_tile_slot_map_test;

    timeunit 1ns;
    timeprecision 1ps;

    import stsm_pkg::*;

    localparam int GRID_W = 8;
    localparam int GRID_H = 8;
    localparam int N_CELLS = GRID_W * GRID_H;

    // Op code 7 is not part of op_t; the block must treat it as a no-op.
    localparam logic [2:0] OP_RESERVED = 3'd7;

    localparam int RANDOM_PER_PHASE = 390;
    localparam int N_PHASES = 4;
    localparam int IDLE_LIMIT = 1000;      // cycles with no transaction on either side
    localparam int SINK_HOLD_AT = 300;     // result count that starts the long sink hold
    localparam int SINK_HOLD_CYCLES = 250;
    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic [5:0] slot;
        logic       hit;
    } tile_result_t;

    // One directed row; fixed marks rows whose answer is typed in.
    typedef struct {
        logic [2:0] op;
        logic [2:0] col;
        logic [2:0] row;
        logic       tile_valid;
        bit         fixed;
        logic [5:0] slot;
        logic       hit;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // col[2:0], row[5:3], tile_valid[6], pad[7]
    logic [2:0] s_axis_tuser = '0;   // op[2:0]
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // slot[5:0], hit[6], pad[7]

    // Bench copy of the block state: slot held by each cell, loaded bit per slot.
    logic [5:0] cell_slot [N_CELLS];
    logic       slot_loaded [N_CELLS];

    tile_result_t pending_results[$];

    int mismatch_count = 0;
    int results_seen = 0;
    int source_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold_left = 0;
    int idle_cycles = 0;

    // Directed table. Answers after reset, at the grid corners, for marks
    // without data, clear-all and the unused op code are typed in; anything
    // that depends on where a scroll moved a slot comes from the predictor.
    stim_row_t directed_rows [] = '{
        '{OP_LOOKUP,   3'd0, 3'd0, 1'b0, 1'b1, 6'd0,  1'b0},
        '{OP_LOOKUP,   3'd7, 3'd7, 1'b1, 1'b1, 6'd63, 1'b0},
        '{OP_MARK,     3'd7, 3'd7, 1'b0, 1'b1, 6'd0,  1'b0},  // mark without data
        '{OP_LOOKUP,   3'd7, 3'd7, 1'b0, 1'b1, 6'd63, 1'b0},
        '{OP_MARK,     3'd7, 3'd7, 1'b1, 1'b1, 6'd0,  1'b0},
        '{OP_LOOKUP,   3'd7, 3'd7, 1'b0, 1'b1, 6'd63, 1'b1},
        '{OP_MARK,     3'd0, 3'd0, 1'b1, 1'b1, 6'd0,  1'b0},
        '{OP_CLEAR,    3'd5, 3'd2, 1'b1, 1'b1, 6'd0,  1'b0},
        '{OP_LOOKUP,   3'd7, 3'd7, 1'b0, 1'b1, 6'd63, 1'b0},
        '{OP_RESERVED, 3'd7, 3'd7, 1'b1, 1'b1, 6'd0,  1'b0},  // unused op code
        '{OP_MARK,     3'd3, 3'd5, 1'b1, 1'b1, 6'd0,  1'b0},
        '{OP_MARK,     3'd0, 3'd0, 1'b1, 1'b1, 6'd0,  1'b0},
        '{OP_DOWN,     3'd0, 3'd0, 1'b0, 1'b1, 6'd0,  1'b0},
        '{OP_LOOKUP,   3'd3, 3'd4, 1'b0, 1'b0, 6'd0,  1'b0},  // mark moved with slot
        '{OP_LOOKUP,   3'd0, 3'd7, 1'b0, 1'b0, 6'd0,  1'b0},  // wrapped slot, cleared
        '{OP_UP,       3'd0, 3'd0, 1'b0, 1'b1, 6'd0,  1'b0},
        '{OP_LEFT,     3'd7, 3'd7, 1'b1, 1'b1, 6'd0,  1'b0},
        '{OP_LOOKUP,   3'd7, 3'd0, 1'b0, 1'b0, 6'd0,  1'b0},
        '{OP_RIGHT,    3'd0, 3'd0, 1'b0, 1'b1, 6'd0,  1'b0},
        '{OP_LOOKUP,   3'd3, 3'd5, 1'b0, 1'b0, 6'd0,  1'b0},
        '{OP_MARK,     3'd7, 3'd0, 1'b1, 1'b1, 6'd0,  1'b0},
        '{OP_RIGHT,    3'd2, 3'd6, 1'b1, 1'b1, 6'd0,  1'b0},
        '{OP_LOOKUP,   3'd0, 3'd0, 1'b0, 1'b0, 6'd0,  1'b0},
        '{OP_LOOKUP,   3'd7, 3'd0, 1'b0, 1'b0, 6'd0,  1'b0}
    };

    scrolling_tile_slot_map #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int cell_index(input int c, input int r);
        return r * GRID_W + c;
    endfunction

    function automatic void reset_slot_map();
        for (int i = 0; i < N_CELLS; i++)
        begin
            cell_slot[i] = 6'(i);
            slot_loaded[i] = 1'b0;
        end
    endfunction

    // Rotate every column one cell. Down: cell (c, r) takes the slot of
    // (c, r+1) and row 0 wraps to the top. The wrapped slot loses its mark.
    function automatic void scroll_columns(input bit down);
        logic [5:0] wrap;
        for (int c = 0; c < GRID_W; c++)
        begin
            if (down)
            begin
                wrap = cell_slot[cell_index(c, 0)];
                for (int r = 0; r < GRID_H - 1; r++)
                    cell_slot[cell_index(c, r)] = cell_slot[cell_index(c, r + 1)];
                cell_slot[cell_index(c, GRID_H - 1)] = wrap;
            end
            else
            begin
                wrap = cell_slot[cell_index(c, GRID_H - 1)];
                for (int r = GRID_H - 1; r > 0; r--)
                    cell_slot[cell_index(c, r)] = cell_slot[cell_index(c, r - 1)];
                cell_slot[cell_index(c, 0)] = wrap;
            end
            slot_loaded[wrap] = 1'b0;
        end
    endfunction

    // Same for rows. Left: cell (c, r) takes the slot of (c+1, r).
    function automatic void scroll_rows(input bit left);
        logic [5:0] wrap;
        for (int r = 0; r < GRID_H; r++)
        begin
            if (left)
            begin
                wrap = cell_slot[cell_index(0, r)];
                for (int c = 0; c < GRID_W - 1; c++)
                    cell_slot[cell_index(c, r)] = cell_slot[cell_index(c + 1, r)];
                cell_slot[cell_index(GRID_W - 1, r)] = wrap;
            end
            else
            begin
                wrap = cell_slot[cell_index(GRID_W - 1, r)];
                for (int c = GRID_W - 1; c > 0; c--)
                    cell_slot[cell_index(c, r)] = cell_slot[cell_index(c - 1, r)];
                cell_slot[cell_index(0, r)] = wrap;
            end
            slot_loaded[wrap] = 1'b0;
        end
    endfunction

    // Apply one op to the bench state and return the answer the block owes.
    // Every position a 3-bit col/row can name lies inside the 8x8 grid.
    function automatic tile_result_t apply_tile_op(input logic [2:0] op,
                                                   input logic [2:0] col,
                                                   input logic [2:0] row,
                                                   input logic tile_valid);
        tile_result_t res;
        int cell_idx;
        res.slot = '0;
        res.hit = 1'b0;
        cell_idx = cell_index(int'(col), int'(row));
        case (op)
            OP_LOOKUP:
            begin
                res.slot = cell_slot[cell_idx];
                res.hit = slot_loaded[cell_slot[cell_idx]];
            end
            OP_MARK:
            begin
                if (tile_valid)
                    slot_loaded[cell_slot[cell_idx]] = 1'b1;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < N_CELLS; i++)
                    slot_loaded[i] = 1'b0;
            end
            OP_DOWN:  scroll_columns(1'b1);
            OP_UP:    scroll_columns(1'b0);
            OP_LEFT:  scroll_rows(1'b1);
            OP_RIGHT: scroll_rows(1'b0);
            default:  ;
        endcase
        return res;
    endfunction

    // Prints are capped so a broken build cannot flood the log; all are counted.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns: result %0d: %s got %0d, want %0d", $time, results_seen,
                     what, got, want);
        mismatch_count++;
    endtask

    // Offer one transaction, wait for acceptance, then log what it must answer.
    // A source gap of random length may come first. tvalid stays high between
    // back-to-back transactions, so it gets one assignment per edge.
    task automatic send_tile_op(input logic [2:0] op, input logic [2:0] col,
                                input logic [2:0] row, input logic tile_valid,
                                input bit fixed, input logic [5:0] fixed_slot,
                                input logic fixed_hit);
        tile_result_t res;
        while ($urandom_range(99) < source_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, tile_valid, row, col};
        s_axis_tuser <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = apply_tile_op(op, col, row, tile_valid);
        if (fixed)
        begin
            res.slot = fixed_slot;
            res.hit = fixed_hit;
        end
        pending_results.push_back(res);
    endtask

    // Random traffic is mostly lookups and marks with data, so marks survive
    // long enough to be seen moving through scrolls; the rest is scrolls,
    // the odd clear-all, the unused op code and marks without data.
    task automatic send_random_op();
        logic [2:0] op;
        int pick;
        pick = $urandom_range(99);
        if (pick < 38)
            op = OP_LOOKUP;
        else if (pick < 68)
            op = OP_MARK;
        else if (pick < 93)
            op = 3'($urandom_range(OP_DOWN, OP_UP));
        else if (pick < 96)
            op = OP_CLEAR;
        else
            op = OP_RESERVED;
        send_tile_op(op, 3'($urandom_range(7)), 3'($urandom_range(7)),
                     ($urandom_range(9) != 0), 1'b0, '0, 1'b0);
    endtask

    // Reset, then the directed table, then the random phases.
    initial
    begin
        reset_slot_map();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_tile_op(directed_rows[i].op, directed_rows[i].col, directed_rows[i].row,
                         directed_rows[i].tile_valid, directed_rows[i].fixed,
                         directed_rows[i].slot, directed_rows[i].hit);

        // Phases: no idling, source gaps, sink stalls, light mix of both.
        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            case (phase)
                0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin source_idle_pct = 56; sink_stall_pct = 0;  end
                2: begin source_idle_pct = 0;  sink_stall_pct = 56; end
                default: begin source_idle_pct = 13; sink_stall_pct = 13; end
            endcase
            repeat (RANDOM_PER_PHASE) send_random_op();
        end
        s_axis_tvalid <= 1'b0;

        // Drain; the watchdog covers a result that never comes.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Sink: checks each accepted result against the oldest expectation and
    // drives tready. After SINK_HOLD_AT results it holds tready low for a
    // long stretch while the source keeps offering, so the output register
    // fills and s_axis_tready must drop.
    initial
    begin
        tile_result_t want;
        logic [5:0] got_slot;
        logic got_hit;
        @(posedge clk iff rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got_slot = m_axis_tdata[5:0];
                got_hit = m_axis_tdata[6];
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, slot", got_slot, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got_slot !== want.slot)
                        report_mismatch("slot", got_slot, want.slot);
                    if (got_hit !== want.hit)
                        report_mismatch("hit", got_hit, want.hit);
                end
                if (results_seen == SINK_HOLD_AT)
                    sink_hold_left = SINK_HOLD_CYCLES;
            end
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: too many cycles without a transaction on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
+incdir+design
design/stsm_pkg.sv
design/stsm_cell.sv
design/scrolling_tile_slot_map.sv
tb/sv/scrolling_tile_slot_map_test.sv
